// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is asserted
`define LPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also covers the reset cycles
`define LPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Types, codes and helper functions of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  // countdown width in bits (8 to 32)
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [32:0] CNT_MAX_W  = (33'd1 << COUNT_BITS) - 33'd1;

  // item opcodes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PLAY = 1'b1
  } op_t;

  // pattern codes
  localparam logic [1:0] PAT_OFF  = 2'd0;
  localparam logic [1:0] PAT_ON   = 2'd1;
  localparam logic [1:0] PAT_SLOW = 2'd2;
  localparam logic [1:0] PAT_FAST = 2'd3;

  // register indexes on the config port
  localparam logic [1:0] REG_REPEAT_MASK = 2'd0;
  localparam logic [1:0] REG_SLOW_TICKS  = 2'd1;
  localparam logic [1:0] REG_FAST_TICKS  = 2'd2;

  // reset values of the registers
  localparam logic [3:0]  RST_REPEAT_MASK = 4'hF;
  localparam logic [15:0] RST_SLOW_TICKS  = 16'd1000;
  localparam logic [15:0] RST_FAST_TICKS  = 16'd250;

  typedef struct packed {
    op_t        op;
    logic [3:0] pattern;
  } in_item_t;

  typedef struct packed {
    logic       led_on;
    logic       accepted;
    logic [1:0] playing_pattern;
  } out_item_t;

  // number of entries in a pattern
  function automatic logic [1:0] entries_of(input logic [1:0] pat);
    return pat[1] ? 2'd2 : 2'd1;
  endfunction

  // led level of an entry
  function automatic logic level_of(input logic [1:0] pat, input logic [1:0] pos);
    logic lvl;
    case (pat)
      PAT_OFF: lvl = 1'b0;
      PAT_ON:  lvl = 1'b1;
      default: lvl = (pos == 2'd0);
    endcase
    return lvl;
  endfunction

  // hold time: zero becomes one, too large saturates at the countdown max
  function automatic logic [COUNT_BITS-1:0] hold_of(input logic [15:0] ticks);
    logic [32:0] t;
    t = {17'd0, ticks};
    if (t == 33'd0) t = 33'd1;
    if (t > CNT_MAX_W) t = CNT_MAX_W;
    return t[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/led_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// Plays off, on, slow blink and fast blink patterns on one LED.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): one item is either a tick or a
//   play request for a pattern. Every item gives exactly one result item on
//   the out channel (out_valid/out_ready/out_data) with the LED level, the
//   accept flag of a play request and the pattern now playing.
//   Config port (APB style, pready always high): repeat_mask at 0x0,
//   slow_ticks at 0x4, fast_ticks at 0x8; write only while no item is in
//   flight.
//   Pipe: an accepted item waits in the item register, and its result is
//   then written to the output register. The item register and the
//   output register form a two-deep pipe, so one item per cycle is taken
//   when the receiver keeps out_ready high; the state update itself is
//   combinational compare and decrement logic.
//   Stall: while out_ready is low the result holds; one more item can wait
//   in the item register, after that in_ready drops.
//   Reset: synchronous, active low; pattern off, LED off, countdown idle,
//   registers back to their defaults, both pipe stages empty.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_top (
  input  logic              clk,
  input  logic              rst_n,
  // item input
  input  logic              in_valid,
  output logic              in_ready,
  input  lps_pkg::in_item_t in_data,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output lps_pkg::out_item_t out_data,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lps_pkg::*;

  // config registers
  logic [3:0]  repeat_mask_r;
  logic [15:0] slow_ticks_r;
  logic [15:0] fast_ticks_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // pipe registers
  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      adv;

  // sequencer state
  logic [1:0]            cur_pat_r, cur_pat_nxt;
  logic [1:0]            cur_pos_r, cur_pos_nxt;
  logic [1:0]            res_pat_r, res_pat_nxt;
  logic [1:0]            res_pos_r, res_pos_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  led_r, led_nxt;
  logic                  acc_nxt;

  // entry selection at countdown expiry
  logic [1:0]            t_pat;
  logic [1:0]            t_pos;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [1:0]            np;

  // config port access
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_REPEAT_MASK: prdata = {28'd0, repeat_mask_r};
      REG_SLOW_TICKS:  prdata = {16'd0, slow_ticks_r};
      REG_FAST_TICKS:  prdata = {16'd0, fast_ticks_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_mask_r <= RST_REPEAT_MASK;
      slow_ticks_r  <= RST_SLOW_TICKS;
      fast_ticks_r  <= RST_FAST_TICKS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_REPEAT_MASK: repeat_mask_r <= pwdata[3:0];
        REG_SLOW_TICKS:  slow_ticks_r  <= pwdata[15:0];
        REG_FAST_TICKS:  fast_ticks_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // handshake: the item stage moves on when the output register frees up
  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = !s1_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // next state for the item in the item register
  assign np      = s1_item_r.pattern[1:0];
  assign cnt_dec = cnt_r - 1'b1;

  always_comb begin
    cur_pat_nxt = cur_pat_r;
    cur_pos_nxt = cur_pos_r;
    res_pat_nxt = res_pat_r;
    res_pos_nxt = res_pos_r;
    cnt_nxt     = cnt_r;
    led_nxt     = led_r;
    acc_nxt     = 1'b0;
    t_pat       = cur_pat_r;
    t_pos       = cur_pos_r;

    if (s1_item_r.op == OP_TICK) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          // past the last entry: wrap, or fall back to the stored pattern
          if (cur_pos_r >= entries_of(cur_pat_r)) begin
            if (repeat_mask_r[cur_pat_r]) begin
              t_pos = 2'd0;
            end else begin
              t_pat = res_pat_r;
              t_pos = res_pos_r;
              if (repeat_mask_r[res_pat_r] || (res_pos_r >= entries_of(res_pat_r))) begin
                t_pos = 2'd0;
              end
            end
          end
          led_nxt     = level_of(t_pat, t_pos);
          cnt_nxt     = t_pat[1] ? hold_of((t_pat == PAT_SLOW) ? slow_ticks_r : fast_ticks_r)
                                 : '0;
          cur_pat_nxt = t_pat;
          cur_pos_nxt = t_pos + 2'd1;
        end
      end
    end else if ((s1_item_r.pattern[3:2] == 2'b00) && (np != cur_pat_r)) begin
      // play request
      if (repeat_mask_r[cur_pat_r]) begin
        acc_nxt = 1'b1;
        if (repeat_mask_r[np]) begin
          cur_pat_nxt = np;
          cur_pos_nxt = 2'd0;
          res_pat_nxt = np;
          res_pos_nxt = 2'd0;
        end else begin
          res_pat_nxt = cur_pat_r;
          res_pos_nxt = cur_pos_r;
          cur_pat_nxt = np;
          cur_pos_nxt = 2'd0;
        end
      end else if (repeat_mask_r[np]) begin
        acc_nxt     = 1'b1;
        res_pat_nxt = np;
        res_pos_nxt = 2'd0;
      end
      if (acc_nxt) begin
        led_nxt = 1'b0;
        cnt_nxt = {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pat_r <= PAT_OFF;
      cur_pos_r <= 2'd0;
      res_pat_r <= PAT_OFF;
      res_pos_r <= 2'd0;
      cnt_r     <= '0;
      led_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (s1_vld_r && adv) begin
      cur_pat_r <= cur_pat_nxt;
      cur_pos_r <= cur_pos_nxt;
      res_pat_r <= res_pat_nxt;
      res_pos_r <= res_pos_nxt;
      cnt_r     <= cnt_nxt;
      led_r     <= led_nxt;
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && adv) begin
      out_item_r.led_on          <= led_nxt;
      out_item_r.accepted        <= acc_nxt;
      out_item_r.playing_pattern <= cur_pat_nxt;
    end
  end

endmodule

// ===== rtl/lps_checker.sv =====
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks of the LED pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input lps_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input lps_pkg::out_item_t out_data,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import lps_pkg::*;

  // a stalled result stays offered
  `LPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `LPS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")

  // input backpressure only comes from a full pipe behind a stalled output
  `LPS_ASSERT(a_ready_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // an accepted play request always starts with the led off
  `LPS_ASSERT(a_acc_led_off, out_valid && out_data.accepted |-> !out_data.led_on, "led lit on accepted play")

  // reset empties both pipe stages
  `LPS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && in_ready, "pipe not empty after reset")

endmodule

bind led_pattern_sequencer_top lps_checker u_lps_checker (.*);
